// File: design/rgb565_fill_engine_assert.svh
// Assertion macros shared by the rgb565 fill engine modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RGB565_FILL_ENGINE_ASSERT_SVH
`define RGB565_FILL_ENGINE_ASSERT_SVH

// same-cycle implication
`define RFE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RFE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rfe_pkg.sv
// Shared constants, codes and types of the rgb565 fill engine.
// No dependencies.
package rfe_pkg;

  localparam int MAX_DIM    = 2048;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int ADDR_W     = 32;
  localparam int COLOR_W    = 16;
  localparam int ARGB_W     = 32;
  localparam int POS_W      = 16;
  localparam int STRIDE_W   = 14;
  localparam int DIM_W      = 12;
  localparam int FUNC_W     = 3;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = COORD_W + STRIDE_W;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HLINE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_VLINE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RECT  = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOB  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BUSY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  localparam logic [ADDR_W-1:0]   BASE_RST   = 32'd0;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 14'd2048;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 12'd1024;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 12'd768;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
  } cfg_t;

  // classified transaction passed from front end to back end
  typedef struct packed {
    logic               is_cmd;
    logic               ok;
    logic               empty;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [PROD_W-1:0]  row_off;
    logic [COLOR_W-1:0] color;
  } entry_t;

  function automatic logic [COLOR_W-1:0] to565(input logic [ARGB_W-1:0] c);
    to565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

endpackage

// File: design/rfe_queue.sv
// Short FIFO between the fill engine front end and back end.
// Depends on rfe_pkg and rgb565_fill_engine_assert.svh.
`include "rgb565_fill_engine_assert.svh"
module rfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rfe_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            head_valid,
  output rfe_pkg::entry_t head
);
  import rfe_pkg::*;

  entry_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = QCNT_W'(cnt_r + QCNT_W'(push) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head       = q_mem_r[rd_ptr_r];

  `RFE_ASSERT_IMPL(a_q_no_overflow, cnt_r == QCNT_W'(QDEPTH), !push, "queue overflow")
  `RFE_ASSERT_IMPL(a_q_no_underflow, cnt_r == '0, !pop, "queue underflow")

endmodule

// File: design/rfe_front.sv
// Front end: accepts transactions, bounds-checks and orders coordinates,
// converts color and computes the row offset. Depends on rfe_pkg.
module rfe_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rfe_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [rfe_pkg::FUNC_W-1:0]   in_func,
  input  logic signed [rfe_pkg::POS_W-1:0]    in_x_first,
  input  logic signed [rfe_pkg::POS_W-1:0]    in_y_first,
  input  logic signed [rfe_pkg::POS_W-1:0]    in_x_second,
  input  logic signed [rfe_pkg::POS_W-1:0]    in_y_second,
  input  logic        [rfe_pkg::ARGB_W-1:0]   in_argb_color,
  input  logic                                pop,
  output logic                                push,
  output rfe_pkg::entry_t                     push_entry
);
  import rfe_pkg::*;

  // credit covers both stages plus the queue
  logic [QCNT_W-1:0]  credit_r, credit_nxt;
  logic               s1_valid_r, s2_valid_r;
  entry_t             s1_r, s1_nxt;
  entry_t             s2_r, s2_nxt;
  logic               accept;
  logic [POS_W-1:0]   xb_sel, yb_sel;
  logic [COORD_W-1:0] xa_t, xb_t, ya_t, yb_t;

  function automatic logic in_range(input logic [POS_W-1:0] v,
                                    input logic [DIM_W-1:0] lim);
    in_range = !v[POS_W-1] && ({1'b0, v} < (POS_W+1)'(lim)) &&
               ({1'b0, v} < (POS_W+1)'(MAX_DIM));
  endfunction

  assign in_stall = (credit_r == QCNT_W'(QDEPTH));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    xb_sel = ((in_func == FUNC_HLINE) || (in_func == FUNC_RECT)) ? in_x_second : in_x_first;
    yb_sel = ((in_func == FUNC_VLINE) || (in_func == FUNC_RECT)) ? in_y_second : in_y_first;
    xa_t   = in_x_first[COORD_W-1:0];
    ya_t   = in_y_first[COORD_W-1:0];
    xb_t   = xb_sel[COORD_W-1:0];
    yb_t   = yb_sel[COORD_W-1:0];

    s1_nxt.is_cmd  = (in_func == FUNC_PIXEL) || (in_func == FUNC_HLINE) ||
                     (in_func == FUNC_VLINE) || (in_func == FUNC_RECT);
    s1_nxt.ok      = in_range(in_x_first, cfg.width) && in_range(xb_sel, cfg.width) &&
                     in_range(in_y_first, cfg.height) && in_range(yb_sel, cfg.height);
    s1_nxt.empty   = (in_func == FUNC_RECT) && (ya_t > yb_t);
    s1_nxt.x0      = (xa_t > xb_t) ? xb_t : xa_t;
    s1_nxt.x1      = (xa_t > xb_t) ? xa_t : xb_t;
    s1_nxt.y0      = (ya_t > yb_t) ? yb_t : ya_t;
    s1_nxt.y1      = (ya_t > yb_t) ? ya_t : yb_t;
    s1_nxt.row_off = '0;
    s1_nxt.color   = to565(in_argb_color);

    s2_nxt         = s1_r;
    s2_nxt.row_off = PROD_W'(s1_r.y0) * PROD_W'(cfg.stride);

    credit_nxt = QCNT_W'(credit_r + QCNT_W'(accept) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r   <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      credit_r   <= credit_nxt;
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

  assign push       = s2_valid_r;
  assign push_entry = s2_r;

endmodule

// File: design/rfe_back.sv
// Back end: holds drawing state, issues at most one pixel write per transaction
// and registers the result. Depends on rfe_pkg and rgb565_fill_engine_assert.svh.
`include "rgb565_fill_engine_assert.svh"
module rfe_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rfe_pkg::cfg_t                   cfg,
  input  logic                            head_valid,
  input  rfe_pkg::entry_t                 head,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_write_valid,
  output logic [rfe_pkg::ADDR_W-1:0]      out_write_address,
  output logic [rfe_pkg::COLOR_W-1:0]     out_write_data,
  output logic [rfe_pkg::STAT_W-1:0]      out_status,
  output logic                            out_last_write,
  output logic                            out_busy_res
);
  import rfe_pkg::*;

  logic               active_r, active_nxt;
  logic [COORD_W-1:0] cur_x_r, cur_x_nxt;
  logic [COORD_W-1:0] cur_y_r, cur_y_nxt;
  logic [COORD_W-1:0] span_x_start_r, span_x_start_nxt;
  logic [COORD_W-1:0] span_x_end_r, span_x_end_nxt;
  logic [COORD_W-1:0] span_y_end_r, span_y_end_nxt;
  logic [ADDR_W-1:0]  row_addr_r, row_addr_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_wv_r, out_wv_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [COLOR_W-1:0] out_data_r, out_data_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_busy_r, out_busy_nxt;

  logic               start, do_emit, step_x, step_y, done;
  logic [COORD_W-1:0] px, py, xs, xe, ye;
  logic [ADDR_W-1:0]  row_sel, emit_addr;
  logic [COLOR_W-1:0] color_sel;

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    start     = head.is_cmd && !active_r && head.ok && !head.empty;
    do_emit   = start || (!head.is_cmd && active_r);
    px        = start ? head.x0 : cur_x_r;
    py        = start ? head.y0 : cur_y_r;
    xs        = start ? head.x0 : span_x_start_r;
    xe        = start ? head.x1 : span_x_end_r;
    ye        = start ? head.y1 : span_y_end_r;
    color_sel = start ? head.color : color_r;
    row_sel   = start ? ADDR_W'(cfg.base + ADDR_W'(head.row_off)) : row_addr_r;
    emit_addr = ADDR_W'(row_sel + ADDR_W'({px, 1'b0}));
    step_x    = (px < xe);
    step_y    = (py < ye);
    done      = !step_x && !step_y;

    active_nxt       = active_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    span_x_start_nxt = span_x_start_r;
    span_x_end_nxt   = span_x_end_r;
    span_y_end_nxt   = span_y_end_r;
    row_addr_nxt     = row_addr_r;
    color_nxt        = color_r;

    out_wv_nxt     = 1'b0;
    out_addr_nxt   = '0;
    out_data_nxt   = '0;
    out_status_nxt = STAT_OK;
    out_last_nxt   = 1'b0;
    out_busy_nxt   = 1'b0;

    if (pop) begin
      if (do_emit) begin
        out_wv_nxt       = 1'b1;
        out_addr_nxt     = emit_addr;
        out_data_nxt     = color_sel;
        out_last_nxt     = done;
        out_busy_nxt     = !done;
        span_x_start_nxt = xs;
        span_x_end_nxt   = xe;
        span_y_end_nxt   = ye;
        color_nxt        = color_sel;
        priority if (step_x) begin
          active_nxt   = 1'b1;
          cur_x_nxt    = COORD_W'(px + 1'b1);
          cur_y_nxt    = py;
          row_addr_nxt = row_sel;
        end else if (step_y) begin
          active_nxt   = 1'b1;
          cur_x_nxt    = xs;
          cur_y_nxt    = COORD_W'(py + 1'b1);
          row_addr_nxt = ADDR_W'(row_sel + ADDR_W'(cfg.stride));
        end else begin
          active_nxt = 1'b0;
        end
      end else if (head.is_cmd) begin
        priority if (active_r) begin
          out_status_nxt = STAT_BUSY;
          out_busy_nxt   = 1'b1;
        end else if (!head.ok) begin
          out_status_nxt = STAT_OOB;
        end else begin
          // empty rectangle
          out_status_nxt = STAT_OK;
        end
      end
    end

    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r       <= 1'b0;
      cur_x_r        <= '0;
      cur_y_r        <= '0;
      span_x_start_r <= '0;
      span_x_end_r   <= '0;
      span_y_end_r   <= '0;
      row_addr_r     <= '0;
      color_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      active_r       <= active_nxt;
      cur_x_r        <= cur_x_nxt;
      cur_y_r        <= cur_y_nxt;
      span_x_start_r <= span_x_start_nxt;
      span_x_end_r   <= span_x_end_nxt;
      span_y_end_r   <= span_y_end_nxt;
      row_addr_r     <= row_addr_nxt;
      color_r        <= color_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_wv_r     <= out_wv_nxt;
      out_addr_r   <= out_addr_nxt;
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
      out_busy_r   <= out_busy_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = out_wv_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_status        = out_status_r;
  assign out_last_write    = out_last_r;
  assign out_busy_res      = out_busy_r;

  `RFE_ASSERT_IMPL(a_last_xor_busy, out_valid_r && out_wv_r,
                   out_last_r != out_busy_r, "write must be last or leave work")
  `RFE_ASSERT_IMPL(a_busy_drop_no_write, out_valid_r && (out_status_r == STAT_BUSY),
                   !out_wv_r && out_busy_r, "busy drop issued a write")
  `RFE_ASSERT_NEXT(a_done_goes_idle, pop && do_emit && done,
                   !active_r, "engine still active after last write")

endmodule

// File: design/rgb565_fill_engine.sv
// RGB565 fill engine: takes one transaction per clock while the output is
// not stalled and returns exactly one result transaction for each, in
// order. A drawing command issues its first pixel write itself; each
// following tick issues the next one, so a fill runs at one pixel write per
// clock while ticks arrive without stalls. Results pass through two
// front-end stages, the queue and an output register; the state update of
// the back end sets the rate. Output stalls stall the input once the
// four-entry queue and front-end stages hold four entries. Configuration
// is taken from the write port at once; registers beyond the index range
// do not exist. Depends on rfe_pkg, rfe_front, rfe_queue and rfe_back.
module rgb565_fill_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic        [rfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [rfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [rfe_pkg::FUNC_W-1:0]  in_func,
  input  logic signed [rfe_pkg::POS_W-1:0]   in_x_first,
  input  logic signed [rfe_pkg::POS_W-1:0]   in_y_first,
  input  logic signed [rfe_pkg::POS_W-1:0]   in_x_second,
  input  logic signed [rfe_pkg::POS_W-1:0]   in_y_second,
  input  logic        [rfe_pkg::ARGB_W-1:0]  in_argb_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_write_valid,
  output logic        [rfe_pkg::ADDR_W-1:0]  out_write_address,
  output logic        [rfe_pkg::COLOR_W-1:0] out_write_data,
  output logic        [rfe_pkg::STAT_W-1:0]  out_status,
  output logic                               out_last_write,
  output logic                               out_busy_res
);
  import rfe_pkg::*;

  cfg_t   cfg_r;
  logic   push, pop, head_valid;
  entry_t push_entry, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base   <= BASE_RST;
      cfg_r.stride <= STRIDE_RST;
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE:   cfg_r.base   <= cfg_wdata[ADDR_W-1:0];
        CFG_STRIDE: cfg_r.stride <= cfg_wdata[STRIDE_W-1:0];
        CFG_WIDTH:  cfg_r.width  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: cfg_r.height <= cfg_wdata[DIM_W-1:0];
      endcase
    end
  end

  rfe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_x_first    (in_x_first),
    .in_y_first    (in_y_first),
    .in_x_second   (in_x_second),
    .in_y_second   (in_y_second),
    .in_argb_color (in_argb_color),
    .pop           (pop),
    .push          (push),
    .push_entry    (push_entry)
  );

  rfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rfe_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_status        (out_status),
    .out_last_write    (out_last_write),
    .out_busy_res      (out_busy_res)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for rgb565_fill_engine: directed and random commands and ticks under several
// frame settings, with its own prediction of every pixel write. Needs rfe_pkg and the RTL.

package fill_check_pkg;
  import rfe_pkg::*;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  x_first;
    logic signed [POS_W-1:0]  y_first;
    logic signed [POS_W-1:0]  x_second;
    logic signed [POS_W-1:0]  y_second;
    logic [ARGB_W-1:0]        argb;
  } fill_cmd_t;

  typedef struct packed {
    logic                write_valid;
    logic [ADDR_W-1:0]   write_address;
    logic [COLOR_W-1:0]  write_data;
    logic [STAT_W-1:0]   status;
    logic                last_write;
    logic                busy_res;
  } pixel_write_t;

  function automatic int dim_limit(logic [DIM_W-1:0] d);
    return (d < DIM_W'(MAX_DIM)) ? int'(d) : MAX_DIM;
  endfunction

  class pixel_writes;
    logic [ADDR_W-1:0]   base;
    logic [STRIDE_W-1:0] stride;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    bit                  drawing;
    int                  x, y, x_start, x_end, y_end;
    logic [ADDR_W-1:0]   row_addr;
    logic [COLOR_W-1:0]  color;
    pixel_write_t        due_writes[$];
    int                  mismatches;

    function new();
      base = BASE_RST;
      stride = STRIDE_RST;
      width = WIDTH_RST;
      height = HEIGHT_RST;
      drawing = 1'b0;
      x = 0; y = 0; x_start = 0; x_end = 0; y_end = 0;
      row_addr = '0;
      color = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BASE:   base = data[ADDR_W-1:0];
        CFG_STRIDE: stride = data[STRIDE_W-1:0];
        CFG_WIDTH:  width = data[DIM_W-1:0];
        CFG_HEIGHT: height = data[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit on_frame(int v, int lim);
      return v >= 0 && v < lim;
    endfunction

    // write at the current position, then move on
    function pixel_write_t step_pixel();
      pixel_write_t w;
      w = '0;
      w.write_valid = 1'b1;
      w.write_address = row_addr + ADDR_W'(x * 2);
      w.write_data = color;
      w.status = STAT_OK;
      if (x < x_end) begin
        x++;
      end else if (y < y_end) begin
        y++;
        x = x_start;
        row_addr = row_addr + ADDR_W'(stride);
      end else begin
        drawing = 1'b0;
      end
      w.last_write = !drawing;
      w.busy_res = drawing;
      return w;
    endfunction

    function void take_item(fill_cmd_t c);
      pixel_write_t w;
      int wl, hl, x0, x1, y0, y1, t;
      w = '0;
      wl = dim_limit(width);
      hl = dim_limit(height);
      if (c.func == FUNC_TICK || c.func > FUNC_RECT) begin
        if (drawing) w = step_pixel();
      end else if (drawing) begin
        w.status = STAT_BUSY;
        w.busy_res = 1'b1;
      end else begin
        x0 = int'($signed(c.x_first));
        y0 = int'($signed(c.y_first));
        x1 = x0;
        y1 = y0;
        if (c.func == FUNC_HLINE || c.func == FUNC_RECT) x1 = int'($signed(c.x_second));
        if (c.func == FUNC_VLINE || c.func == FUNC_RECT) y1 = int'($signed(c.y_second));
        if (!(on_frame(x0, wl) && on_frame(x1, wl) && on_frame(y0, hl) && on_frame(y1, hl))) begin
          w.status = STAT_OOB;
        end else if (!(c.func == FUNC_RECT && y0 > y1)) begin
          if (x0 > x1) begin t = x0; x0 = x1; x1 = t; end
          if (y0 > y1) begin t = y0; y0 = y1; y1 = t; end
          x_start = x0;
          x_end = x1;
          y_end = y1;
          x = x0;
          y = y0;
          row_addr = base + ADDR_W'(y0 * int'(stride));
          color = {c.argb[23:19], c.argb[15:10], c.argb[7:3]};
          drawing = 1'b1;
          w = step_pixel();
        end
      end
      due_writes.push_back(w);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_write(pixel_write_t got);
      pixel_write_t want;
      if (due_writes.size() == 0) begin
        mismatches++;
        $error("result transaction with no pending expectation");
        return;
      end
      want = due_writes.pop_front();
      if (got.write_valid !== want.write_valid)
        report("write_valid", 32'(want.write_valid), 32'(got.write_valid));
      if (got.write_address !== want.write_address)
        report("write_address", want.write_address, got.write_address);
      if (got.write_data !== want.write_data)
        report("write_data", 32'(want.write_data), 32'(got.write_data));
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
      if (got.last_write !== want.last_write)
        report("last_write", 32'(want.last_write), 32'(got.last_write));
      if (got.busy_res !== want.busy_res)
        report("busy_res", 32'(want.busy_res), 32'(got.busy_res));
    endfunction
  endclass
endpackage

module testbench;
  import rfe_pkg::*;
  import fill_check_pkg::*;

  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_RECT + 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [FUNC_W-1:0]       in_func;
  logic signed [POS_W-1:0] in_x_first;
  logic signed [POS_W-1:0] in_y_first;
  logic signed [POS_W-1:0] in_x_second;
  logic signed [POS_W-1:0] in_y_second;
  logic [ARGB_W-1:0]       in_argb_color;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_write_valid;
  logic [ADDR_W-1:0]       out_write_address;
  logic [COLOR_W-1:0]      out_write_data;
  logic [STAT_W-1:0]       out_status;
  logic                    out_last_write;
  logic                    out_busy_res;

  pixel_writes  tracker;
  pixel_write_t seen;
  int           cycles = 0;
  int           items_sent = 0;
  bit           quiet = 1'b0;
  bit           hold_req = 1'b0;

  rgb565_fill_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_x_first(in_x_first), .in_y_first(in_y_first),
    .in_x_second(in_x_second), .in_y_second(in_y_second),
    .in_argb_color(in_argb_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_write_valid(out_write_valid), .out_write_address(out_write_address),
    .out_write_data(out_write_data), .out_status(out_status),
    .out_last_write(out_last_write), .out_busy_res(out_busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      seen.write_valid = out_write_valid;
      seen.write_address = out_write_address;
      seen.write_data = out_write_data;
      seen.status = out_status;
      seen.last_write = out_last_write;
      seen.busy_res = out_busy_res;
      tracker.check_write(seen);
    end
  end

  // result side pacing; a requested hold-off is counted here
  initial begin
    int burst;
    int held;
    burst = 0;
    held = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) begin
          hold_req = 1'b0;
          held = 0;
        end
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 9);
      end
    end
  end

  task automatic send_item(fill_cmd_t c);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= c.func;
    in_x_first <= c.x_first;
    in_y_first <= c.y_first;
    in_x_second <= c.x_second;
    in_y_second <= c.y_second;
    in_argb_color <= c.argb;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.take_item(c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(logic [FUNC_W-1:0] f, int xa, int ya, int xb, int yb,
                             logic [ARGB_W-1:0] argb);
    fill_cmd_t c;
    c.func = f;
    c.x_first = POS_W'(xa);
    c.y_first = POS_W'(ya);
    c.x_second = POS_W'(xb);
    c.y_second = POS_W'(yb);
    c.argb = argb;
    send_item(c);
  endtask

  task automatic send_tick();
    fill_cmd_t c;
    c.func = ($urandom_range(0, 3) == 0) ?
             FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI)) : FUNC_TICK;
    c.x_first = POS_W'($urandom);
    c.y_first = POS_W'($urandom);
    c.x_second = POS_W'($urandom);
    c.y_second = POS_W'($urandom);
    c.argb = $urandom;
    send_item(c);
  endtask

  function automatic logic [POS_W-1:0] probe_coord(int lim);
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return POS_W'(lim - 1);
      3: return POS_W'(lim);
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic send_noise(bit cmd_only);
    fill_cmd_t c;
    int wl, hl;
    wl = dim_limit(tracker.width);
    hl = dim_limit(tracker.height);
    c.func = cmd_only ? FUNC_W'($urandom_range(FUNC_PIXEL, FUNC_RECT)) :
                        FUNC_W'($urandom_range(FUNC_TICK, FUNC_SPARE_HI));
    c.x_first = probe_coord(wl);
    c.y_first = probe_coord(hl);
    c.x_second = probe_coord(wl);
    c.y_second = probe_coord(hl);
    c.argb = $urandom;
    send_item(c);
  endtask

  task automatic pick_span(int lim, int maxlen, output int a, output int b);
    int len, t;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, maxlen) : $urandom_range(1, 4);
    if (len > maxlen) len = maxlen;
    if (len > lim) len = lim;
    a = $urandom_range(0, lim - 1);
    if ($urandom_range(0, 4) == 0) a = $urandom_range(0, 1) ? 0 : lim - 1;
    b = (a + len - 1 < lim) ? a + len - 1 : a - len + 1;
    if ($urandom_range(0, 3) == 0) begin
      t = a; a = b; b = t;
    end
  endtask

  // one drawing command followed by the ticks that drain it, with stray commands mixed in
  task automatic draw_sequence();
    fill_cmd_t c;
    int xa, xb, ya, yb, nx, ny, n;
    bit wide, tall;
    c.func = FUNC_W'($urandom_range(FUNC_PIXEL, FUNC_RECT));
    wide = (c.func == FUNC_HLINE || c.func == FUNC_RECT);
    tall = (c.func == FUNC_VLINE || c.func == FUNC_RECT);
    pick_span(dim_limit(tracker.width), !wide ? 1 : (c.func == FUNC_RECT ? 12 : 64), xa, xb);
    pick_span(dim_limit(tracker.height), !tall ? 1 : (c.func == FUNC_RECT ? 12 : 64), ya, yb);
    c.x_first = POS_W'(xa);
    c.y_first = POS_W'(ya);
    c.x_second = wide ? POS_W'(xb) : POS_W'($urandom);
    c.y_second = tall ? POS_W'(yb) : POS_W'($urandom);
    c.argb = $urandom;
    nx = wide ? ((xb > xa) ? xb - xa : xa - xb) + 1 : 1;
    ny = tall ? ((yb > ya) ? yb - ya : ya - yb) + 1 : 1;
    n = (c.func == FUNC_RECT && ya > yb) ? 0 : nx * ny;
    send_item(c);
    for (int k = 1; k < n; k++) begin
      if ($urandom_range(0, 11) == 0) send_noise(1'b1);
      send_tick();
    end
  endtask

  task automatic run_random(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 4) == 0 || dim_limit(tracker.width) == 0 ||
          dim_limit(tracker.height) == 0) begin
        send_noise(1'b0);
      end else begin
        while (tracker.drawing) send_tick();
        draw_sequence();
      end
    end
    while (tracker.drawing) send_tick();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.due_writes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    tracker.set_reg(idx, data);
    @(negedge clk);
  endtask

  // narrow registers get random upper bits, which must be ignored
  task automatic apply_cfg(logic [31:0] base, int stride, int width, int height);
    write_reg(CFG_BASE, base);
    write_reg(CFG_STRIDE, (($urandom >> STRIDE_W) << STRIDE_W) | 32'(stride));
    write_reg(CFG_WIDTH, (($urandom >> DIM_W) << DIM_W) | 32'(width));
    write_reg(CFG_HEIGHT, (($urandom >> DIM_W) << DIM_W) | 32'(height));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic directed_items();
    send_fields(FUNC_TICK, 0, 0, 0, 0, '0);
    send_fields(FUNC_PIXEL, 0, 0, -32768, 32767, 32'hFFFF_FFFF);
    send_fields(FUNC_PIXEL, 1023, 767, 32767, -32768, 32'h0000_0000);
    send_fields(FUNC_PIXEL, -1, 0, 0, 0, 32'h00FF_0000);
    send_fields(FUNC_PIXEL, 1024, 0, 0, 0, 32'h0000_FF00);
    send_fields(FUNC_PIXEL, 32767, -32768, 0, 0, 32'h0000_00FF);
    // reversed line, busy command and spare codes in the middle
    send_fields(FUNC_HLINE, 5, 3, 2, 0, 32'hA5A5_5A5A);
    send_fields(FUNC_TICK, 0, 0, 0, 0, '0);
    send_fields(FUNC_VLINE, 1, 1, 1, 1, 32'h1234_5678);
    send_fields(FUNC_SPARE_HI, -1, -1, -1, -1, 32'hFFFF_FFFF);
    send_fields(FUNC_TICK, 0, 0, 0, 0, '0);
    send_fields(FUNC_VLINE, 10, 4, -5, 1, 32'h8040_2010);
    send_fields(FUNC_SPARE_LO, 0, 0, 0, 0, '0);
    send_fields(FUNC_TICK, 0, 0, 0, 0, '0);
    send_fields(FUNC_TICK, 0, 0, 0, 0, '0);
    send_fields(FUNC_RECT, 2, 1, 0, 2, 32'h5500_AA55);
    repeat (5) send_fields(FUNC_TICK, 0, 0, 0, 0, '0);
    send_fields(FUNC_RECT, 0, 5, 1, 3, 32'h0F0F_0F0F);
    send_fields(FUNC_RECT, 0, 0, 1024, 1, 32'hF0F0_F0F0);
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = '0;
    in_x_first = '0;
    in_y_first = '0;
    in_x_second = '0;
    in_y_second = '0;
    in_argb_color = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_items();
    drain();

    apply_cfg($urandom, 1280, 640, 480);
    run_random(130);
    drain();

    apply_cfg(32'hFFFF_FFF0, 16383, 2048, 2048);
    hold_req = 1'b1;
    run_random(130);
    drain();

    apply_cfg(32'h0000_0000, 2, 1, 1);
    run_random(80);
    drain();

    apply_cfg($urandom, 0, 4095, 4095);
    run_random(130);
    drain();

    apply_cfg($urandom, 8192, 0, 16);
    run_random(30);
    drain();

    apply_cfg($urandom, 8191, 16, 0);
    run_random(30);
    drain();

    apply_cfg($urandom, $urandom_range(2, 8192), $urandom_range(1, 2048),
              $urandom_range(1, 2048));
    run_random(150);
    drain();

    quiet = 1'b1;
    apply_cfg($urandom, $urandom_range(2, 8192), $urandom_range(1, 2048),
              $urandom_range(1, 2048));
    run_random(150);
    drain();

    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: rgb565_fill_engine.f
+incdir+design
design/rfe_pkg.sv
design/rfe_queue.sv
design/rfe_front.sv
design/rfe_back.sv
design/rgb565_fill_engine.sv
verif/testbench.sv
